[design/rri_pkg.sv]
// Shared types and constants for the ray/rectangle intersection core.
package rri_pkg;

  localparam int DIV_STEPS = 33;           // quotient bits produced by the divider chain
  localparam int DIV_LANES = 4;            // lane 0: distance t, lanes 1..3: x, y, z offsets
  localparam int REM_W     = 33;           // partial remainder width
  localparam int DIVD_W    = 58;           // dividend width

  localparam logic [2:0] REG_CORNER = 3'd0;
  localparam logic [2:0] REG_EDGE_A = 3'd1;
  localparam logic [2:0] REG_EDGE_B = 3'd2;
  localparam logic [2:0] REG_NORMAL = 3'd3;
  localparam logic [2:0] REG_LEN_A  = 3'd4;
  localparam logic [2:0] REG_LEN_B  = 3'd5;

  typedef logic [DIV_LANES-1:0][REM_W-1:0]     rem_vec_t;
  typedef logic [DIV_LANES-1:0][DIV_STEPS-1:0] quo_vec_t;

  // Sideband that rides along with each ray through the divider chain.
  typedef struct packed {
    logic                  miss;
    logic [DIV_LANES-1:0]  ovf;
    logic [2:0][15:0]      org;
    logic [2:0]            dneg;
  } side_t;

endpackage

[design/rri_front.sv]
// Front end: plane dot products, sign fix, epsilon test, dividend forming, overflow check and divider seed.
module rri_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [15:0]     origin_x,
  input  logic signed [15:0]     origin_y,
  input  logic signed [15:0]     origin_z,
  input  logic signed [15:0]     direction_x,
  input  logic signed [15:0]     direction_y,
  input  logic signed [15:0]     direction_z,
  input  logic [47:0]            corner_xyz,
  input  logic [47:0]            plane_normal_xyz,
  output logic                   out_valid,
  output logic [31:0]            out_den,
  output rri_pkg::rem_vec_t      out_rem,
  output rri_pkg::quo_vec_t      out_quo,
  output rri_pkg::side_t         out_side
);

  localparam int DIVD_LANES_M1 = rri_pkg::DIV_LANES - 1;

  // stage 1: products
  logic                      v1;
  logic signed [32:0]        pn1 [3];
  logic signed [31:0]        pd1 [3];
  logic [2:0][15:0]          o1;
  logic [2:0][15:0]          d1;
  // stage 2: sums, sign fix
  logic                      v2;
  logic signed [35:0]        num2;
  logic [31:0]               den2;
  logic                      zero2;
  logic [2:0][15:0]          o2;
  logic [2:0][15:0]          d2;
  // stage 3: epsilon, dividends
  logic                      v3;
  logic                      miss3;
  logic [31:0]               den3;
  logic [DIVD_LANES_M1:0][rri_pkg::DIVD_W-1:0] x3;
  logic [2:0][15:0]          o3;
  logic [2:0]                dneg3;

  logic [2:0][15:0]          o_in;
  logic [2:0][15:0]          d_in;
  logic signed [35:0]        num_s;
  logic signed [33:0]        den_s;
  logic signed [45:0]        num_k;
  logic [33:0]               num_mag;

  assign o_in = {origin_z, origin_y, origin_x};
  assign d_in = {direction_z, direction_y, direction_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    for (int k = 0; k < 3; k++) begin
      pn1[k] <= ($signed({corner_xyz[16*k+15], corner_xyz[16*k +: 16]})
                 - $signed({o_in[k][15], o_in[k]})) * $signed(plane_normal_xyz[16*k +: 16]);
      pd1[k] <= $signed(d_in[k]) * $signed(plane_normal_xyz[16*k +: 16]);
    end
    o1 <= o_in;
    d1 <= d_in;
  end

  assign num_s = 36'(pn1[0]) + 36'(pn1[1]) + 36'(pn1[2]);
  assign den_s = 34'(pd1[0]) + 34'(pd1[1]) + 34'(pd1[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    num2  <= den_s[33] ? -num_s : num_s;
    den2  <= den_s[33] ? 32'(-den_s) : 32'(den_s);
    zero2 <= (den_s == 34'sd0);
    o2    <= o1;
    d2    <= d1;
  end

  // miss when t <= 0.001, i.e. 1000*num <= den
  assign num_k   = 46'(num2) * 46'sd1000;
  assign num_mag = num2[33:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    miss3 <= zero2 | (num_k <= $signed({14'b0, den2}));
    den3  <= den2;
    x3[0] <= {8'b0, num_mag, 16'b0};
    for (int k = 0; k < 3; k++) begin
      x3[k+1] <= {(50'(d2[k][15] ? 16'(-d2[k]) : d2[k]) * 50'(num_mag)), 8'b0};
      dneg3[k] <= d2[k][15];
    end
    o3 <= o2;
  end

  // stage 4: overflow check and divider seed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    out_den       <= den3;
    out_side.miss <= miss3;
    out_side.org  <= o3;
    out_side.dneg <= dneg3;
    for (int i = 0; i < rri_pkg::DIV_LANES; i++) begin
      out_side.ovf[i] <= ({7'b0, x3[i][57:33]} >= den3);
      out_rem[i]      <= {8'b0, x3[i][57:33]};
      out_quo[i]      <= x3[i][32:0];
    end
  end

endmodule

[design/rri_div_stage.sv]
// One restoring-division step for all lanes, registered.
module rri_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        in_den,
  input  rri_pkg::rem_vec_t  in_rem,
  input  rri_pkg::quo_vec_t  in_quo,
  input  rri_pkg::side_t     in_side,
  output logic               out_valid,
  output logic [31:0]        out_den,
  output rri_pkg::rem_vec_t  out_rem,
  output rri_pkg::quo_vec_t  out_quo,
  output rri_pkg::side_t     out_side
);

  logic [rri_pkg::DIV_LANES-1:0][33:0] trial;
  logic [rri_pkg::DIV_LANES-1:0]       ge;
  logic [rri_pkg::DIV_LANES-1:0][33:0] diff;

  always_comb begin
    for (int i = 0; i < rri_pkg::DIV_LANES; i++) begin
      trial[i] = {in_rem[i], in_quo[i][rri_pkg::DIV_STEPS-1]};
      diff[i]  = trial[i] - {2'b0, in_den};
      ge[i]    = (trial[i] >= {2'b0, in_den});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den  <= in_den;
    out_side <= in_side;
    for (int i = 0; i < rri_pkg::DIV_LANES; i++) begin
      out_rem[i] <= ge[i] ? diff[i][32:0] : trial[i][32:0];
      out_quo[i] <= {in_quo[i][rri_pkg::DIV_STEPS-2:0], ge[i]};
    end
  end

endmodule

[design/rri_back.sv]
// Back end: saturation, hit point, edge projections and result register.
module rri_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rri_pkg::quo_vec_t  in_quo,
  input  rri_pkg::side_t     in_side,
  input  logic [47:0]        corner_xyz,
  input  logic [47:0]        edge_a_xyz,
  input  logic [47:0]        edge_b_xyz,
  input  logic [31:0]        edge_a_len_sq,
  input  logic [31:0]        edge_b_len_sq,
  output logic               done,
  output logic               hit_flag,
  output logic [31:0]        hit_distance,
  output logic signed [31:0] hit_point_x,
  output logic signed [31:0] hit_point_y,
  output logic signed [31:0] hit_point_z
);

  localparam logic signed [35:0] P_MAX = 36'sd2147483647;
  localparam logic signed [35:0] P_MIN = -36'sd2147483648;

  logic                     v1, miss1;
  logic [31:0]              tq1;
  logic [2:0][31:0]         p1;
  logic                     v2, miss2;
  logic [31:0]              tq2;
  logic [2:0][31:0]         p2;
  logic signed [49:0]       ta2 [3];
  logic signed [49:0]       tb2 [3];

  logic [2:0][33:0]         mag;
  logic signed [35:0]       psum [3];
  logic signed [33:0]       rel  [3];
  logic signed [51:0]       pa, pb;
  logic                     hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = in_side.ovf[k+1] ? 34'h2_0000_0000 : {1'b0, in_quo[k+1]};
      psum[k] = in_side.dneg[k]
              ? $signed({{12{in_side.org[k][15]}}, in_side.org[k], 8'b0}) - $signed({2'b0, mag[k]})
              : $signed({{12{in_side.org[k][15]}}, in_side.org[k], 8'b0}) + $signed({2'b0, mag[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    miss1 <= in_side.miss;
    tq1   <= (in_side.ovf[0] | in_quo[0][32]) ? 32'hFFFF_FFFF : in_quo[0][31:0];
    for (int k = 0; k < 3; k++) begin
      if (psum[k] > P_MAX) begin
        p1[k] <= 32'h7FFF_FFFF;
      end else if (psum[k] < P_MIN) begin
        p1[k] <= 32'h8000_0000;
      end else begin
        p1[k] <= psum[k][31:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rel[k] = 34'($signed(p1[k]))
             - $signed({{2{corner_xyz[16*k+15]}}, corner_xyz[16*k +: 16], 8'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    miss2 <= miss1;
    tq2   <= tq1;
    p2    <= p1;
    for (int k = 0; k < 3; k++) begin
      ta2[k] <= 50'(rel[k]) * 50'($signed(edge_a_xyz[16*k +: 16]));
      tb2[k] <= 50'(rel[k]) * 50'($signed(edge_b_xyz[16*k +: 16]));
    end
  end

  assign pa  = 52'(ta2[0]) + 52'(ta2[1]) + 52'(ta2[2]);
  assign pb  = 52'(tb2[0]) + 52'(tb2[1]) + 52'(tb2[2]);
  assign hit = !miss2
             && !pa[51] && (pa <= $signed({12'b0, edge_a_len_sq, 8'b0}))
             && !pb[51] && (pb <= $signed({12'b0, edge_b_len_sq, 8'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    hit_flag     <= hit;
    hit_distance <= hit ? tq2 : 32'd0;
    hit_point_x  <= hit ? p2[0] : 32'd0;
    hit_point_y  <= hit ? p2[1] : 32'd0;
    hit_point_z  <= hit ? p2[2] : 32'd0;
  end

endmodule

[design/ray_rectangle_intersect_core.sv]
// Top level: register file, front end, divider chain and back end.
//
// Ray/rectangle intersection, one ray per clock.
// Command channel: a ray (origin, direction, signed Q8.8) transfers at a rising
// edge with start high and busy low. busy is always low: every ray is taken.
// Result channel: done pulses for one cycle with hit_flag, hit_distance (Q16.16)
// and the hit point (signed Q16.16). A miss returns all fields zero.
// From the start transfer to the done cycle a ray passes through:
//   4 front stages (dot products, sign fix, epsilon test, divider seed),
//   33 restoring-division stages, one quotient bit per stage, four lanes
//   (t and the three hit point offsets) sharing one divisor,
//   3 back stages (saturation, projections, compare and output register).
// Throughput is one ray per cycle; most of the latency lies in the divider chain.
// The receiver cannot stall; results leave on their done cycle.
// Reset clears all valid bits and the configuration registers to zero.
// APB writes are taken at any time but must only happen while no ray is in
// flight. Register i sits at byte address 8*i, data 64 bits.
module ray_rectangle_intersect_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  input  logic signed [15:0] direction_x,
  input  logic signed [15:0] direction_y,
  input  logic signed [15:0] direction_z,
  output logic               done,
  output logic               hit_flag,
  output logic [31:0]        hit_distance,
  output logic signed [31:0] hit_point_x,
  output logic signed [31:0] hit_point_y,
  output logic signed [31:0] hit_point_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int NSTG = rri_pkg::DIV_STEPS;

  logic [47:0] corner_xyz, edge_a_xyz, edge_b_xyz, plane_normal_xyz;
  logic [31:0] edge_a_len_sq, edge_b_len_sq;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign busy    = 1'b0;   // fully pipelined, never refuses a ray
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_xyz       <= '0;
      edge_a_xyz       <= '0;
      edge_b_xyz       <= '0;
      plane_normal_xyz <= '0;
      edge_a_len_sq    <= '0;
      edge_b_len_sq    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rri_pkg::REG_CORNER: corner_xyz       <= pwdata[47:0];
        rri_pkg::REG_EDGE_A: edge_a_xyz       <= pwdata[47:0];
        rri_pkg::REG_EDGE_B: edge_b_xyz       <= pwdata[47:0];
        rri_pkg::REG_NORMAL: plane_normal_xyz <= pwdata[47:0];
        rri_pkg::REG_LEN_A:  edge_a_len_sq    <= pwdata[31:0];
        rri_pkg::REG_LEN_B:  edge_b_len_sq    <= pwdata[31:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rri_pkg::REG_CORNER: prdata = {16'b0, corner_xyz};
      rri_pkg::REG_EDGE_A: prdata = {16'b0, edge_a_xyz};
      rri_pkg::REG_EDGE_B: prdata = {16'b0, edge_b_xyz};
      rri_pkg::REG_NORMAL: prdata = {16'b0, plane_normal_xyz};
      rri_pkg::REG_LEN_A:  prdata = {32'b0, edge_a_len_sq};
      rri_pkg::REG_LEN_B:  prdata = {32'b0, edge_b_len_sq};
      default:             prdata = '0;
    endcase
  end

  // divider chain: index 0 is the front end output, NSTG the last step
  logic               dv   [NSTG+1];
  logic [31:0]        dden [NSTG+1];
  rri_pkg::rem_vec_t  drem [NSTG+1];
  rri_pkg::quo_vec_t  dquo [NSTG+1];
  rri_pkg::side_t     dside[NSTG+1];

  rri_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start & ~busy),
    .origin_x         (origin_x),
    .origin_y         (origin_y),
    .origin_z         (origin_z),
    .direction_x      (direction_x),
    .direction_y      (direction_y),
    .direction_z      (direction_z),
    .corner_xyz       (corner_xyz),
    .plane_normal_xyz (plane_normal_xyz),
    .out_valid        (dv[0]),
    .out_den          (dden[0]),
    .out_rem          (drem[0]),
    .out_quo          (dquo[0]),
    .out_side         (dside[0])
  );

  for (genvar s = 0; s < NSTG; s++) begin : g_div
    rri_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[s]),
      .in_den    (dden[s]),
      .in_rem    (drem[s]),
      .in_quo    (dquo[s]),
      .in_side   (dside[s]),
      .out_valid (dv[s+1]),
      .out_den   (dden[s+1]),
      .out_rem   (drem[s+1]),
      .out_quo   (dquo[s+1]),
      .out_side  (dside[s+1])
    );
  end

  rri_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (dv[NSTG]),
    .in_quo        (dquo[NSTG]),
    .in_side       (dside[NSTG]),
    .corner_xyz    (corner_xyz),
    .edge_a_xyz    (edge_a_xyz),
    .edge_b_xyz    (edge_b_xyz),
    .edge_a_len_sq (edge_a_len_sq),
    .edge_b_len_sq (edge_b_len_sq),
    .done          (done),
    .hit_flag      (hit_flag),
    .hit_distance  (hit_distance),
    .hit_point_x   (hit_point_x),
    .hit_point_y   (hit_point_y),
    .hit_point_z   (hit_point_z)
  );

endmodule

[sim/tb_ray_rectangle_intersect_core.sv]
// Self-checking testbench for ray_rectangle_intersect_core: directed and random rays.
module tb_ray_rectangle_intersect_core;

  // Cycles with no transfer on either side before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  // Latency from start transfer to done, with margin.
  localparam int DRAIN_CYCLES = 45;
  localparam int EPS_SCALE = 1000;

  typedef struct {
    logic               hit;
    logic [31:0]        tdist;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } ray_result_t;

  // Expected-result store plus a private copy of the rectangle registers.
  class hit_scoreboard;
    bit [63:0]   rect_regs[6];
    ray_result_t pending[$];

    function void set_reg(logic [2:0] idx, bit [63:0] value);
      case (idx)
        rri_pkg::REG_CORNER, rri_pkg::REG_EDGE_A, rri_pkg::REG_EDGE_B,
        rri_pkg::REG_NORMAL: rect_regs[idx] = value[47:0];
        rri_pkg::REG_LEN_A, rri_pkg::REG_LEN_B: rect_regs[idx] = value[31:0];
        default: ;
      endcase
    endfunction

    function longint comp(logic [2:0] idx, int k);
      logic signed [15:0] v;
      v = rect_regs[idx][16*k +: 16];
      return longint'(v);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Intersect one ray with the configured rectangle and queue the outcome.
    function void note_ray(logic signed [15:0] ox, oy, oz, dx, dy, dz);
      longint o[3], d[3], p[3];
      longint num, den, tq, pa, pb, rel;
      ray_result_t r;
      o = '{longint'(ox), longint'(oy), longint'(oz)};
      d = '{longint'(dx), longint'(dy), longint'(dz)};
      r = '{hit: 1'b0, tdist: '0, px: '0, py: '0, pz: '0};
      num = 0; den = 0; pa = 0; pb = 0;
      for (int k = 0; k < 3; k++) begin
        num += (comp(rri_pkg::REG_CORNER, k) - o[k]) * comp(rri_pkg::REG_NORMAL, k);
        den += d[k] * comp(rri_pkg::REG_NORMAL, k);
      end
      // Parallel ray or zero normal: miss.
      if (den != 0) begin
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        // Epsilon test, exact: t must exceed 1/1000.
        if (num * EPS_SCALE > den) begin
          tq = (num * 65536) / den;
          if (tq > 64'sh0_FFFF_FFFF) tq = 64'sh0_FFFF_FFFF;
          for (int k = 0; k < 3; k++) begin
            p[k] = clamp32(o[k] * 256 + (d[k] * num * 256) / den);
            rel = p[k] - comp(rri_pkg::REG_CORNER, k) * 256;
            pa += rel * comp(rri_pkg::REG_EDGE_A, k);
            pb += rel * comp(rri_pkg::REG_EDGE_B, k);
          end
          if (pa >= 0 && pa <= longint'(rect_regs[rri_pkg::REG_LEN_A] << 8) &&
              pb >= 0 && pb <= longint'(rect_regs[rri_pkg::REG_LEN_B] << 8)) begin
            r.hit   = 1'b1;
            r.tdist = tq[31:0];
            r.px    = p[0][31:0];
            r.py    = p[1][31:0];
            r.pz    = p[2][31:0];
          end
        end
      end
      pending.push_back(r);
    endfunction

    // Returns an empty string on a match, else a description of the mismatch.
    function string check(ray_result_t got);
      ray_result_t want;
      if (pending.size() == 0) return "result with no ray outstanding";
      want = pending.pop_front();
      if (got.hit !== want.hit || got.tdist !== want.tdist || got.px !== want.px ||
          got.py !== want.py || got.pz !== want.pz)
        return $sformatf("got hit=%0b t=%h p=(%h %h %h) want hit=%0b t=%h p=(%h %h %h)",
                         got.hit, got.tdist, got.px, got.py, got.pz,
                         want.hit, want.tdist, want.px, want.py, want.pz);
      return "";
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] origin_x, origin_y, origin_z;
  logic signed [15:0] direction_x, direction_y, direction_z;
  logic               done;
  logic               hit_flag;
  logic [31:0]        hit_distance;
  logic signed [31:0] hit_point_x, hit_point_y, hit_point_z;
  logic               psel, penable, pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  hit_scoreboard sb;
  int            mismatches;
  int            hang_count;
  int            sender_idle_pct;

  ray_rectangle_intersect_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .direction_x(direction_x), .direction_y(direction_y), .direction_z(direction_z),
    .done(done), .hit_flag(hit_flag), .hit_distance(hit_distance),
    .hit_point_x(hit_point_x), .hit_point_y(hit_point_y), .hit_point_z(hit_point_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Monitor: ray transfers feed the scoreboard, done cycles are checked.
  // Sampling happens at the edge, before this step's driver updates land.
  always @(posedge clk) begin
    bit          moved;
    string       msg;
    ray_result_t got;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        sb.note_ray(origin_x, origin_y, origin_z, direction_x, direction_y, direction_z);
        moved = 1'b1;
      end
      if (done) begin
        got = '{hit: hit_flag, tdist: hit_distance, px: hit_point_x, py: hit_point_y,
                pz: hit_point_z};
        msg = sb.check(got);
        if (msg != "") report(msg);
        moved = 1'b1;
      end
    end
    hang_count = moved ? 0 : hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // APB write: setup cycle, then the access cycle (pready is always high).
  // The bus then idles so back-to-back writes start on a fresh edge.
  task automatic write_reg(logic [2:0] idx, bit [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [63:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  task automatic write_rect(bit [63:0] c, bit [63:0] a, bit [63:0] b, bit [63:0] n,
                            bit [63:0] la, bit [63:0] lb);
    write_reg(rri_pkg::REG_CORNER, c);
    write_reg(rri_pkg::REG_EDGE_A, a);
    write_reg(rri_pkg::REG_EDGE_B, b);
    write_reg(rri_pkg::REG_NORMAL, n);
    write_reg(rri_pkg::REG_LEN_A, la);
    write_reg(rri_pkg::REG_LEN_B, lb);
  endtask

  // Holds start high from the current edge until the transfer edge.
  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    start       <= 1'b1;
    origin_x    <= 16'(ox);
    origin_y    <= 16'(oy);
    origin_z    <= 16'(oz);
    direction_x <= 16'(dx);
    direction_y <= 16'(dy);
    direction_z <= 16'(dz);
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Let every outstanding ray come back, then idle out the pipeline.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly rays aimed at the plane near the rectangle; the rest full-range noise.
  task automatic random_ray();
    if ($urandom_range(99) < 70)
      send_ray($urandom_range(2048) - 1024, $urandom_range(2048) - 1024, $urandom_range(512),
               $urandom_range(2048) - 1024, $urandom_range(2048) - 1024,
               $urandom_range(1024, 64));
    else
      send_ray($urandom & 16'hFFFF, $urandom & 16'hFFFF, $urandom & 16'hFFFF,
               $urandom & 16'hFFFF, $urandom & 16'hFFFF, $urandom & 16'hFFFF);
  endtask

  task automatic random_batch(int count);
    int saved_pct;
    saved_pct = sender_idle_pct;
    for (int i = 0; i < count; i++) begin
      // Idle-free stretch in the middle of each batch.
      if (i == count / 3) sender_idle_pct = 0;
      if (i == 2 * count / 3) sender_idle_pct = saved_pct;
      random_ray();
    end
  endtask

  initial begin
    int pct[4];
    sb = new();
    mismatches = 0;
    hang_count = 0;
    sender_idle_pct = 0;
    pct = '{0, 45, 0, 19};
    rst = 1'b1;
    start = 1'b0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    direction_x = '0; direction_y = '0; direction_z = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: zero normal, every ray misses.
    send_ray(100, -200, 300, 5, 6, 7);
    send_ray(-32768, -32768, -32768, -32768, -32768, -32768);
    drain();

    // Square [-2,2]x[-2,2] at z=5, normal +z.
    write_rect(pack3(-512, -512, 1280), pack3(1024, 0, 0), pack3(0, 1024, 0),
               pack3(0, 0, 256), 64'd16 << 16, 64'd16 << 16);
    send_ray(0, 0, 0, 0, 0, 256);               // center hit
    send_ray(-512, -512, 0, 0, 0, 256);         // exactly on the corner
    send_ray(512, 512, 0, 0, 0, 256);           // far corner
    send_ray(513, 0, 0, 0, 0, 256);             // just outside edge a
    send_ray(0, 0, 0, 256, 0, 0);               // parallel to the plane
    send_ray(0, 0, 0, 0, 0, 0);                 // zero direction
    send_ray(0, 0, 0, 0, 0, -256);              // pointing away
    send_ray(0, 0, 1279, 0, 0, 1000);           // t exactly at epsilon
    send_ray(0, 0, 1279, 0, 0, 999);            // t just above epsilon
    send_ray(0, 0, 2000, 0, 0, -256);           // from behind the plane
    send_ray(0, 0, -32768, 0, 0, 1);            // huge t, distance still below saturation
    send_ray(32767, 32767, 32767, 32767, 32767, 32767);
    send_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    send_ray(0, 0, 0, -32768, 32767, 1);        // saturated hit point
    send_ray(32767, -32768, 0, -32768, 32767, 256);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_rect(pack3(-512, -512, 1280), pack3(1024, 0, 0), pack3(0, 1024, 0),
                      pack3(0, 0, 256), 64'd16 << 16, 64'd16 << 16);
        // Tilted plane, normal scaled negative so the denominator flips.
        1: write_rect(pack3(-512, -256, 640), pack3(1024, 0, 0), pack3(0, 1024, -512),
                      pack3(0, -128, -256), 64'd16 << 16, 64'd20 << 16);
        2: write_rect({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        3: write_rect(pack3(32767, 32767, 32767), pack3(32767, 32767, 32767),
                      pack3(32767, 32767, 32767), pack3(32767, 32767, 32767),
                      64'hFFFF_FFFF, 64'hFFFF_FFFF);
        default: write_rect(pack3(-32768, -32768, -32768), pack3(-32768, -32768, -32768),
                            pack3(-32768, 32767, -32768), pack3(-32768, -32768, -32768),
                            64'd0, 64'd0);
      endcase
      sender_idle_pct = pct[ph % 4];
      random_batch(110);
      // Hold the sender off until every expected result is back.
      if (ph == 1) drain();
      sender_idle_pct = pct[(ph + 1) % 4];
      random_batch(107);
      drain();
    end

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
design/rri_pkg.sv
design/rri_front.sv
design/rri_div_stage.sv
design/rri_back.sv
design/ray_rectangle_intersect_core.sv
sim/tb_ray_rectangle_intersect_core.sv
